// ===== design/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rstn, prop)
`define ASSERT_ALL(label, clk, prop)

`endif

`endif

// ===== design/abkg_pkg.sv =====
// Types, codes and NAL header classification for the keyframe gate.
package abkg_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_RESTART = 2'd1,
        MODE_START   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        VERDICT_FORWARD     = 3'd0,
        VERDICT_FORWARD_HDR = 3'd1,
        VERDICT_CACHED      = 3'd2,
        VERDICT_REJECT      = 3'd3,
        VERDICT_NOT_READY   = 3'd4
    } verdict_t;

    localparam logic [4:0] H264_IDR = 5'd5;
    localparam logic [4:0] H264_SPS = 5'd7;
    localparam logic [4:0] H264_PPS = 5'd8;
    localparam logic [5:0] HEVC_IDR_W_RADL = 6'd19;
    localparam logic [5:0] HEVC_IDR_N_LP   = 6'd20;
    localparam logic [5:0] HEVC_VPS = 6'd32;
    localparam logic [5:0] HEVC_SPS = 6'd33;
    localparam logic [5:0] HEVC_PPS = 6'd34;

    localparam logic [31:0] LONG_CODE  = 32'h0000_0001;
    localparam logic [23:0] SHORT_CODE = 24'h00_0001;
    localparam logic [2:0]  HIST_FULL  = 3'd4;

    typedef struct packed {
        logic key;
        logic params;
    } hdr_class_t;

    function automatic hdr_class_t classify_header(input logic [7:0] hdr,
                                                   input logic       hevc);
        hdr_class_t c;
        logic [5:0] ht;
        logic [4:0] at;
        ht = hdr[6:1];
        at = hdr[4:0];
        if (hevc) begin
            c.key    = (ht == HEVC_IDR_W_RADL) || (ht == HEVC_IDR_N_LP);
            c.params = (ht == HEVC_VPS) || (ht == HEVC_SPS) || (ht == HEVC_PPS);
        end else begin
            c.key    = (at == H264_IDR);
            c.params = (at == H264_SPS) || (at == H264_PPS);
        end
        return c;
    endfunction

endpackage

// ===== design/annexb_access_unit_keyframe_gate_core.sv =====
// Annex-B access unit scanner and keyframe gate; one byte word per cycle when m_axis flows.
// Input register feeds scan logic and result register, whose verdict words drive m_axis.
// Throughput: one word per cycle while m_axis_tready does not hold the result register.
// A result waiting on m_axis_tready does not block intake while the input register is free.
// Reset: synchronous active-low aresetn clears scan state, gate state and codec_hevc;
// the words in flight are dropped.
`include "assert_macros.svh"

module annexb_access_unit_keyframe_gate_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,       // codec_hevc
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [7:0] data_byte, [8] pipeline_ready
    input  logic [1:0]  s_axis_tuser,    // [1:0] mode
    input  logic        s_axis_tlast,    // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata     // [2:0] verdict, [3] has_key_frame,
                                         // [4] has_parameter_sets
);
    import abkg_pkg::*;

    logic        codec_hevc_reg;

    // input register
    logic        in_valid_reg;
    mode_t       in_mode_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_ready_reg;

    // scan and gate state
    logic [31:0] hist_reg, hist_next;
    logic [2:0]  seen_reg, seen_next;
    logic        pend_reg, pend_next;
    logic [7:0]  pend_hdr_reg, pend_hdr_next;
    logic        unit_key_reg, unit_key_next;
    logic        unit_params_reg, unit_params_next;
    logic        kf_seen_reg, kf_seen_next;
    logic        hdr_cached_reg, hdr_cached_next;
    logic        any_fwd_reg, any_fwd_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;

    logic        out_free;
    logic        proc;
    logic        long_hit;
    logic        short_hit;
    logic        key_acc;
    logic        params_acc;
    hdr_class_t  pend_cls;
    hdr_class_t  byte_cls;
    verdict_t    verdict;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign pend_cls  = classify_header(pend_hdr_reg, codec_hevc_reg);
    assign byte_cls  = classify_header(in_byte_reg, codec_hevc_reg);
    assign long_hit  = (seen_reg >= HIST_FULL) && (hist_reg == LONG_CODE);
    assign short_hit = !long_hit && (seen_reg >= 3'd3) && (hist_reg[23:0] == SHORT_CODE);

    // a pending short-code header counts once any further byte arrives
    assign key_acc    = unit_key_reg || (pend_reg && pend_cls.key)
                        || (long_hit && byte_cls.key);
    assign params_acc = unit_params_reg || (pend_reg && pend_cls.params)
                        || (long_hit && byte_cls.params);

    always_comb begin
        verdict = VERDICT_FORWARD;
        if (!in_ready_reg) begin
            verdict = VERDICT_NOT_READY;
        end else if (!kf_seen_reg && !key_acc) begin
            verdict = params_acc ? VERDICT_CACHED : VERDICT_REJECT;
        end else if (key_acc && !any_fwd_reg && hdr_cached_reg) begin
            verdict = VERDICT_FORWARD_HDR;
        end
    end

    always_comb begin
        hist_next        = hist_reg;
        seen_next        = seen_reg;
        pend_next        = pend_reg;
        pend_hdr_next    = pend_hdr_reg;
        unit_key_next    = unit_key_reg;
        unit_params_next = unit_params_reg;
        kf_seen_next     = kf_seen_reg;
        hdr_cached_next  = hdr_cached_reg;
        any_fwd_next     = any_fwd_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        if (proc) begin
            case (in_mode_reg)
                MODE_BYTE: begin
                    if (in_last_reg) begin
                        hist_next        = '0;
                        seen_next        = '0;
                        pend_next        = 1'b0;
                        pend_hdr_next    = '0;
                        unit_key_next    = 1'b0;
                        unit_params_next = 1'b0;
                        out_valid_next   = 1'b1;
                        out_data_next    = {3'b000, params_acc, key_acc, verdict};
                        if (in_ready_reg) begin
                            if (verdict == VERDICT_CACHED) begin
                                hdr_cached_next = 1'b1;
                            end
                            if (verdict == VERDICT_FORWARD ||
                                verdict == VERDICT_FORWARD_HDR) begin
                                kf_seen_next = kf_seen_reg || key_acc;
                                any_fwd_next = 1'b1;
                            end
                        end
                    end else begin
                        hist_next        = {hist_reg[23:0], in_byte_reg};
                        seen_next        = (seen_reg < HIST_FULL) ? seen_reg + 3'd1 : seen_reg;
                        pend_next        = short_hit;
                        pend_hdr_next    = short_hit ? in_byte_reg : 8'h00;
                        unit_key_next    = key_acc;
                        unit_params_next = params_acc;
                    end
                end
                MODE_RESTART: begin
                    kf_seen_next = 1'b0;
                end
                MODE_START: begin
                    hist_next        = '0;
                    seen_next        = '0;
                    pend_next        = 1'b0;
                    pend_hdr_next    = '0;
                    unit_key_next    = 1'b0;
                    unit_params_next = 1'b0;
                    kf_seen_next     = 1'b0;
                    hdr_cached_next  = 1'b0;
                    any_fwd_next     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_hevc_reg  <= 1'b0;
            in_valid_reg    <= 1'b0;
            hist_reg        <= '0;
            seen_reg        <= '0;
            pend_reg        <= 1'b0;
            pend_hdr_reg    <= '0;
            unit_key_reg    <= 1'b0;
            unit_params_reg <= 1'b0;
            kf_seen_reg     <= 1'b0;
            hdr_cached_reg  <= 1'b0;
            any_fwd_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                codec_hevc_reg <= cfg_wdata;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            hist_reg        <= hist_next;
            seen_reg        <= seen_next;
            pend_reg        <= pend_next;
            pend_hdr_reg    <= pend_hdr_next;
            unit_key_reg    <= unit_key_next;
            unit_params_reg <= unit_params_next;
            kf_seen_reg     <= kf_seen_next;
            hdr_cached_reg  <= hdr_cached_next;
            any_fwd_reg     <= any_fwd_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_mode_reg  <= mode_t'(s_axis_tuser);
            in_byte_reg  <= s_axis_tdata[7:0];
            in_last_reg  <= s_axis_tlast;
            in_ready_reg <= s_axis_tdata[8];
        end
        out_data_reg <= out_data_next;
    end

    `ASSERT_ALL(a_seen_sat, aclk, !aresetn || (seen_reg <= HIST_FULL))
    `ASSERT_RST(a_pend_full, aclk, aresetn, pend_reg |-> (seen_reg == HIST_FULL))
    `ASSERT_RST(a_fwd_hdr_key, aclk, aresetn,
        (m_axis_tvalid && (m_axis_tdata[2:0] == VERDICT_FORWARD_HDR)) |-> m_axis_tdata[3])
    `ASSERT_RST(a_rise_from_last, aclk, aresetn,
        $rose(out_valid_reg) |-> $past(proc && in_mode_reg == MODE_BYTE && in_last_reg))
    `ASSERT_RST(a_cache_clear, aclk, aresetn,
        $fell(hdr_cached_reg) |-> $past(proc && in_mode_reg == MODE_START))

endmodule

// ===== sim/annexb_gate_monitor.sv =====
// Watches both channels of the keyframe gate, predicts every verdict word and compares.
`timescale 1ns / 1ps

module annexb_gate_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import abkg_pkg::*;

    typedef struct {
        verdict_t verdict;
        logic     key;
        logic     params;
    } au_result_t;

    au_result_t expected_verdicts[$];

    // shadow copy of the block
    logic        hevc;
    logic [31:0] hist;
    logic [2:0]  hist_cnt;
    logic        short_pend;
    logic [7:0]  short_hdr;
    logic        au_key;
    logic        au_params;
    logic        kf_seen;
    logic        hdr_cached;
    logic        fwd_any;

    int err_cnt;
    int chk_cnt;

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        err_cnt    = 0;
        chk_cnt    = 0;
    end

    // returns {is_param, is_key}
    function automatic logic [1:0] nal_kind(input logic [7:0] hdr, input logic is_hevc);
        logic [5:0] t6;
        logic [4:0] t5;
        t6 = 6'((hdr >> 1) & 8'h3f);
        t5 = 5'(hdr & 8'h1f);
        if (is_hevc)
            return {(t6 == HEVC_VPS || t6 == HEVC_SPS || t6 == HEVC_PPS),
                    (t6 == HEVC_IDR_W_RADL || t6 == HEVC_IDR_N_LP)};
        return {(t5 == H264_SPS || t5 == H264_PPS), (t5 == H264_IDR)};
    endfunction

    task automatic note_nal(input logic [7:0] hdr);
        logic [1:0] k;
        k = nal_kind(hdr, hevc);
        if (k[0]) au_key = 1'b1;
        if (k[1]) au_params = 1'b1;
    endtask

    task automatic clear_scan();
        hist       = '0;
        hist_cnt   = '0;
        short_pend = 1'b0;
        short_hdr  = '0;
        au_key     = 1'b0;
        au_params  = 1'b0;
    endtask

    task automatic predict_gate(input logic [1:0] md, input logic [7:0] b,
                                input logic lst, input logic rdy);
        au_result_t r;
        if (md == MODE_RESTART) begin
            kf_seen = 1'b0;
        end else if (md == MODE_START) begin
            clear_scan();
            kf_seen    = 1'b0;
            hdr_cached = 1'b0;
            fwd_any    = 1'b0;
        end else if (md == MODE_BYTE) begin
            // a following byte confirms a header behind a 3-byte code
            if (short_pend) begin
                note_nal(short_hdr);
                short_pend = 1'b0;
                short_hdr  = '0;
            end
            if (hist_cnt >= HIST_FULL && hist == LONG_CODE) begin
                note_nal(b);
            end else if (hist_cnt >= 3'd3 && hist[23:0] == SHORT_CODE) begin
                short_pend = 1'b1;
                short_hdr  = b;
            end
            hist = {hist[23:0], b};
            if (hist_cnt < HIST_FULL)
                hist_cnt = hist_cnt + 3'd1;
            if (lst) begin
                if (!rdy) begin
                    r.verdict = VERDICT_NOT_READY;
                end else begin
                    r.verdict = VERDICT_FORWARD;
                    if (!kf_seen) begin
                        if (!au_key && au_params) begin
                            hdr_cached = 1'b1;
                            r.verdict  = VERDICT_CACHED;
                        end else if (!au_key) begin
                            r.verdict = VERDICT_REJECT;
                        end else begin
                            kf_seen = 1'b1;
                        end
                    end
                    if (r.verdict == VERDICT_FORWARD) begin
                        if (au_key && !fwd_any && hdr_cached)
                            r.verdict = VERDICT_FORWARD_HDR;
                        fwd_any = 1'b1;
                    end
                end
                r.key    = au_key;
                r.params = au_params;
                expected_verdicts.push_back(r);
                clear_scan();
            end
        end
        // mode 3 is ignored
    endtask

    always @(posedge aclk) begin
        au_result_t want;
        if (!aresetn) begin
            hevc = 1'b0;
            clear_scan();
            kf_seen    = 1'b0;
            hdr_cached = 1'b0;
            fwd_any    = 1'b0;
            expected_verdicts.delete();
        end else begin
            if (cfg_we)
                hevc = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                chk_cnt++;
                if (expected_verdicts.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: unexpected verdict word %02h", m_axis_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_axis_tdata[2:0] !== want.verdict || m_axis_tdata[3] !== want.key ||
                        m_axis_tdata[4] !== want.params) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("ERROR: verdict word %0d: exp v=%0d k=%b p=%b, %s",
                                     chk_cnt, want.verdict, want.key, want.params,
                                     $sformatf("got v=%0d k=%b p=%b", m_axis_tdata[2:0],
                                               m_axis_tdata[3], m_axis_tdata[4]));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_gate(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[8]);
        end
        fail_count <= err_cnt;
        pending    <= expected_verdicts.size();
        checked    <= chk_cnt;
    end

endmodule

// ===== sim/annexb_access_unit_keyframe_gate_core_tb.sv =====
// Stimulus and verdict for the Annex-B keyframe gate core.
`timescale 1ns / 1ps

module annexb_access_unit_keyframe_gate_core_tb;
    import abkg_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_wdata     = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int checked;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int words_sent = 0;
    logic [7:0] au_bytes[$];

    always #6 aclk = ~aclk;

    annexb_access_unit_keyframe_gate_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    annexb_gate_monitor i_monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic send_word(input logic [1:0] md, input logic [7:0] b,
                             input logic lst, input logic rdy);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= md;
        s_axis_tdata  <= {7'd0, rdy, b};
        s_axis_tlast  <= lst;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        words_sent++;
    endtask

    // side words carry random payload so every bit toggles
    task automatic send_side(input logic [1:0] md);
        logic [8:0] r;
        r = 9'($urandom);
        send_word(md, r[7:0], r[8], 1'($urandom));
    endtask

    task automatic send_unit(input logic rdy);
        for (int i = 0; i < au_bytes.size(); i++) begin
            if ($urandom_range(99) < 3)
                send_side(MODE_RESTART);
            else if ($urandom_range(99) < 2)
                send_side(MODE_UNUSED);
            send_word(MODE_BYTE, au_bytes[i], (i == au_bytes.size() - 1), rdy);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
        // words without a verdict may still be in the pipe
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_codec(input logic hevc);
        cfg_we    <= 1'b1;
        cfg_wdata <= hevc;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_header(input logic hevc);
        logic [7:0] r;
        int sel;
        r   = 8'($urandom);
        sel = $urandom_range(9);
        if (hevc) begin
            if (sel < 4)
                return {r[7], (r[6] ? HEVC_IDR_N_LP : HEVC_IDR_W_RADL), r[0]};
            if (sel < 7)
                return {r[7], (r[6] ? HEVC_PPS : (r[5] ? HEVC_SPS : HEVC_VPS)), r[0]};
        end else begin
            if (sel < 4)
                return {r[7:5], H264_IDR};
            if (sel < 7)
                return {r[7:5], (r[4] ? H264_PPS : H264_SPS)};
        end
        return r;
    endfunction

    task automatic build_unit(input logic hevc);
        int n;
        logic [7:0] r;
        au_bytes.delete();
        if ($urandom_range(99) < 15) begin
            // noise rich in zeros and ones
            n = $urandom_range(1, 12);
            repeat (n) begin
                r = 8'($urandom);
                case ($urandom_range(2))
                    0: au_bytes.push_back(8'h00);
                    1: au_bytes.push_back(8'h01);
                    default: au_bytes.push_back(r);
                endcase
            end
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(1))
                    au_bytes.push_back(8'h00);
                au_bytes.push_back(8'h00);
                au_bytes.push_back(8'h00);
                au_bytes.push_back(8'h01);
                au_bytes.push_back(pick_header(hevc));
                repeat ($urandom_range(0, 4))
                    au_bytes.push_back(8'($urandom));
            end
        end
    endtask

    initial begin
        int seg_words;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: cache, discarded trailing header, not ready, restart, forward
        send_side(MODE_START);
        au_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00};
        send_unit(1'b1);
        au_bytes = '{8'h00, 8'h00, 8'h01, 8'h65};
        send_unit(1'b1);
        au_bytes = '{8'h00, 8'h00, 8'h01, 8'h65, 8'hff};
        send_unit(1'b0);
        send_side(MODE_RESTART);
        send_side(MODE_UNUSED);
        au_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65};
        send_unit(1'b1);
        au_bytes = '{8'hff};
        send_unit(1'b1);
        wait_idle();

        // two codec settings under each idle mix
        for (int seg = 0; seg < 8; seg++) begin
            case (seg >> 1)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
                default: begin src_idle_pct = 6; snk_stall_pct = 6; end
            endcase
            write_codec(1'(seg & 1));
            seg_words = words_sent;
            while (words_sent - seg_words < 125) begin
                if ($urandom_range(99) < 2)
                    send_side(MODE_START);
                build_unit(1'(seg & 1));
                send_unit($urandom_range(99) < 85);
            end
            wait_idle();
        end

        $display("%0d words sent across both codecs and four idle/stall mixes", words_sent);
        $display("%0d verdict words checked", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(12 * 400_000);
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
